// File: hw/rtl/wmf_pkg.sv
// Shared types and constants of the window median filter.
package wmf_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 12;
  localparam int RADIUS_W    = 2;
  localparam int OUT_COL_W   = 10;
  localparam int ROW_W       = 12;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // take a pixel, read and write the line stores
    logic load;     // shift the window and start the selection
    logic sel_step; // resolve one median bit
    logic publish;  // move the median into the output register
  } wmf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;     // current centre is interior
    logic sel_done; // last median bit resolved in this step
    logic out_busy; // output register holds an untaken transaction
  } wmf_sts_t;

endpackage

// File: hw/rtl/window_median_filter_unit.sv
// Top level of the square-window median filter.
// A border pixel is only accepted and loaded into the window and gives no transaction; for
// an interior pixel the result reaches the output register through window load, one
// rank-select step per pixel bit and publish, plus any output stall. A new pixel is accepted
// only after the previous one has left this sequence (in_stall is high outside idle).
// Reset (rst_n, synchronous): counters, window and control cleared, config to defaults.
module window_median_filter_unit import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2,
  parameter int PIXEL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PIXEL_BITS-1:0]  in_pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIXEL_BITS-1:0]  out_median,
  output logic [OUT_COL_W-1:0]   out_centre_column,
  output logic [ROW_W-1:0]       out_centre_row,
  output logic                   out_last
);

  wmf_cmd_t cmd;
  wmf_sts_t sts;

  wmf_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_pixel          (in_pixel),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_median        (out_median),
    .out_centre_column (out_centre_column),
    .out_centre_row    (out_centre_row),
    .out_last          (out_last)
  );

endmodule

// File: hw/rtl/wmf_datapath.sv
// Datapath: configuration, counters, line stores, window and bitwise median select.
module wmf_datapath import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2,
  parameter int PIXEL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [PIXEL_BITS-1:0]  in_pixel,
  input  logic                   out_stall,
  input  wmf_cmd_t               cmd,
  output wmf_sts_t               sts,
  output logic                   out_valid,
  output logic [PIXEL_BITS-1:0]  out_median,
  output logic [OUT_COL_W-1:0]   out_centre_column,
  output logic [ROW_W-1:0]       out_centre_row,
  output logic                   out_last
);

  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int LINES  = 2 * MAX_RADIUS;
  localparam int NWIN   = SIDE * SIDE;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(LINES);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int DIAM_W = $clog2(LINES + 1);
  localparam int RANK_W = $clog2(NWIN + 1);
  localparam int BIT_W  = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
  localparam int EW     = (((COL_W + 1) > (WIDTH_W + 1)) ? (COL_W + 1) : (WIDTH_W + 1));
  localparam int HW     = HEIGHT_W + 1;

  // Configuration registers
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [RADIUS_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_data[HEIGHT_W-1:0];
        CFG_WINDOW_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry after clamping
  logic [RAD_W-1:0]  r_eff;
  logic [DIAM_W-1:0] diam;
  logic [EW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;

  always_comb begin
    r_eff = (32'(radius_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_r);
    diam  = DIAM_W'({r_eff, 1'b0});
    if (width_r == '0)
      w_eff = EW'(1);
    else if (EW'(width_r) > EW'(MAX_WIDTH))
      w_eff = EW'(MAX_WIDTH);
    else
      w_eff = EW'(width_r);
    h_eff = (height_r == '0) ? HW'(1) : HW'(height_r);
  end

  // Raster counters and the captured transaction
  logic [COL_W-1:0]      col_r, cur_col_r;
  logic [ROW_W-1:0]      row_r, cur_row_r;
  logic [SLOT_W-1:0]     slot_r, cur_slot_r;
  logic [PIXEL_BITS-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (cmd.accept) begin
      if (EW'(col_r) + EW'(1) >= w_eff) begin
        col_r <= '0;
        if (HW'(row_r) + HW'(1) >= h_eff) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_r + ROW_W'(1);
          slot_r <= (32'(slot_r) == LINES - 1) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_col_r  <= col_r;
      cur_row_r  <= row_r;
      cur_slot_r <= slot_r;
      pix_r      <= in_pixel;
    end
  end

  // Line stores, one memory per slot, read before write at the current column
  logic [PIXEL_BITS-1:0] rd_q [LINES];

  for (genvar g = 0; g < LINES; g++) begin : g_line
    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (cmd.accept) begin
        rd_q[g] <= mem[col_r];
        if (slot_r == SLOT_W'(g))
          mem[col_r] <= in_pixel;
      end
    end
  end

  // Newest window column
  logic [PIXEL_BITS-1:0] new_col [SIDE];

  always_comb begin
    logic [SLOT_W:0] s;
    logic [DIAM_W-1:0] back;
    for (int k = 0; k < SIDE; k++) begin
      back = diam - DIAM_W'(k);
      s    = (SLOT_W+1)'(cur_slot_r) + (SLOT_W+1)'(LINES) - (SLOT_W+1)'(back);
      if (s >= (SLOT_W+1)'(LINES))
        s = s - (SLOT_W+1)'(LINES);
      if (DIAM_W'(k) < diam)
        new_col[k] = rd_q[s[SLOT_W-1:0]];
      else if (DIAM_W'(k) == diam)
        new_col[k] = pix_r;
      else
        new_col[k] = '0;
    end
  end

  // Window registers, column-shifted on load
  logic [PIXEL_BITS-1:0] win_r [NWIN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NWIN; i++)
        win_r[i] <= '0;
    end else if (cmd.load) begin
      for (int c = SIDE - 1; c > 0; c--)
        for (int k = 0; k < SIDE; k++)
          win_r[c*SIDE+k] <= win_r[(c-1)*SIDE+k];
      for (int k = 0; k < SIDE; k++)
        win_r[k] <= new_col[k];
    end
  end

  // Interior test and last flag of the captured pixel
  logic emit, last_flag;
  assign emit = (DIAM_W'(cur_col_r) >= diam || 32'(cur_col_r) >= LINES + 1)
                && (32'(cur_row_r) >= 32'(diam));
  assign last_flag = (EW'(cur_col_r) == w_eff - EW'(1)) && (HW'(cur_row_r) == h_eff - HW'(1));

  // Bitwise rank select, most significant bit first
  logic [NWIN-1:0]       active_r;
  logic [RANK_W-1:0]     rank_r;
  logic [BIT_W-1:0]      bit_r;
  logic [PIXEL_BITS-1:0] med_r;
  logic [NWIN-1:0]       active_init, plane;
  logic [RANK_W-1:0]     rank_init, cnt0;

  always_comb begin
    for (int c = 0; c < SIDE; c++)
      for (int k = 0; k < SIDE; k++)
        active_init[c*SIDE+k] = (DIAM_W'(c) <= diam) && (DIAM_W'(k) <= diam);
    rank_init = RANK_W'((((32'(diam) + 1) * (32'(diam) + 1)) + 1) >> 1);
    for (int i = 0; i < NWIN; i++)
      plane[i] = win_r[i][bit_r];
    cnt0 = RANK_W'($countones(active_r & ~plane));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      active_r <= active_init;
      rank_r   <= rank_init;
      bit_r    <= BIT_W'(PIXEL_BITS - 1);
    end else if (cmd.sel_step) begin
      if (rank_r <= cnt0) begin
        med_r[bit_r] <= 1'b0;
        active_r     <= active_r & ~plane;
      end else begin
        med_r[bit_r] <= 1'b1;
        active_r     <= active_r & plane;
        rank_r       <= rank_r - cnt0;
      end
      bit_r <= bit_r - BIT_W'(1);
    end
  end

  // Output register
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_median_r;
  logic [OUT_COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]      out_row_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (cmd.publish)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_median_r <= med_r;
      out_col_r    <= OUT_COL_W'(cur_col_r - COL_W'(r_eff));
      out_row_r    <= cur_row_r - ROW_W'(r_eff);
      out_last_r   <= last_flag;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_median        = out_median_r;
  assign out_centre_column = out_col_r;
  assign out_centre_row    = out_row_r;
  assign out_last          = out_last_r;

  assign sts.emit     = emit;
  assign sts.sel_done = (bit_r == '0);
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

// File: hw/rtl/wmf_controller.sv
// Controller: sequences accept, window load, median select and publish.
module wmf_controller import wmf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wmf_sts_t sts,
  output wmf_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid)
          state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sts.emit ? ST_SEL : ST_IDLE;
      end
      ST_SEL: begin
        cmd.sel_step = 1'b1;
        if (sts.sel_done)
          state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_LOAD))
    else $error("accepted transaction not followed by window load");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !sts.out_busy)
    else $error("publish over an untaken transaction");

  a_sel_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL && sts.sel_done) |=> (state_r == ST_DONE))
    else $error("selection end not followed by publish state");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.load, cmd.sel_step, cmd.publish}))
    else $error("more than one command at once");

endmodule

// File: test/tb_window_median_filter_unit.sv
// Self-checking testbench of the square-window median filter unit.
`timescale 1ns / 1ps

module tb_window_median_filter_unit;
  import wmf_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int RADIUS_CAP = 2;
  localparam int SLOTS      = 2 * RADIUS_CAP;
  localparam int SIDE_CAP   = 2 * RADIUS_CAP + 1;
  localparam int SETTLE     = 24;

  typedef struct {
    bit [7:0]  median;
    bit [9:0]  column;
    bit [11:0] row;
    bit        last;
  } filt_result_t;

  // Shadow of the filter state; predicts each median and checks the output
  class median_scoreboard;
    bit [WIDTH_W-1:0]  width_r;
    bit [HEIGHT_W-1:0] height_r;
    bit [RADIUS_W-1:0] radius_r;
    bit [7:0]          lines [SLOTS][LINE_DEPTH];
    bit [7:0]          win [SIDE_CAP][SIDE_CAP];
    int                col_q;
    int                row_q;
    filt_result_t      pending_q[$];
    int                errors;
    int                results;

    function new();
      width_r  = WIDTH_RESET;
      height_r = HEIGHT_RESET;
      radius_r = RADIUS_RESET;
      col_q    = 0;
      row_q    = 0;
      errors   = 0;
      results  = 0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:   width_r  = val[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r = val[HEIGHT_W-1:0];
        CFG_WINDOW_RADIUS: radius_r = val[RADIUS_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_radius();
      return (radius_r > RADIUS_CAP) ? RADIUS_CAP : int'(radius_r);
    endfunction

    function int eff_width();
      if (width_r == 0) return 1;
      return (width_r > LINE_DEPTH) ? LINE_DEPTH : int'(width_r);
    endfunction

    function int eff_height();
      return (height_r == 0) ? 1 : int'(height_r);
    endfunction

    // Shift in one pixel, update line stores and counters, queue any median
    function void note_pixel(bit [7:0] pix);
      int r, w, h, col, row, slot, side, n, v, k;
      int vals [SIDE_CAP*SIDE_CAP];
      filt_result_t res;
      r   = eff_radius();
      w   = eff_width();
      h   = eff_height();
      col = col_q % LINE_DEPTH;
      row = row_q;
      for (int j = SIDE_CAP - 1; j > 0; j--)
        for (int i = 0; i < SIDE_CAP; i++) win[j][i] = win[j-1][i];
      for (int i = 0; i < SIDE_CAP; i++) win[0][i] = '0;
      for (int i = 0; i < 2 * r; i++) begin
        slot = (row + SLOTS - (2 * r - i)) % SLOTS;
        win[0][i] = lines[slot][col];
      end
      win[0][2*r] = pix;
      lines[row % SLOTS][col] = pix;
      if (col >= 2 * r && row >= 2 * r) begin
        side = 2 * r + 1;
        n = 0;
        for (int i = 0; i < side; i++)
          for (int j = 0; j < side; j++) begin
            vals[n] = win[i][j];
            n++;
          end
        // insertion sort, then take rank (n+1)/2
        for (int i = 1; i < n; i++) begin
          v = vals[i];
          k = i;
          while (k > 0 && vals[k-1] > v) begin
            vals[k] = vals[k-1];
            k--;
          end
          vals[k] = v;
        end
        res.median = 8'(vals[(n + 1) / 2 - 1]);
        res.column = 10'(col - r);
        res.row    = 12'(row - r);
        res.last   = (col == w - 1 && row == h - 1);
        pending_q.push_back(res);
      end
      if (col + 1 >= w) begin
        col_q = 0;
        row_q = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col_q = col + 1;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(filt_result_t got);
      filt_result_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected transaction median %0d col %0d row %0d",
                         got.median, got.column, got.row));
        return;
      end
      exp_r = pending_q.pop_front();
      results++;
      if (got.median != exp_r.median)
        report($sformatf("median %0d, want %0d (col %0d row %0d)",
                         got.median, exp_r.median, exp_r.column, exp_r.row));
      if (got.column != exp_r.column)
        report($sformatf("column %0d, want %0d", got.column, exp_r.column));
      if (got.row != exp_r.row)
        report($sformatf("row %0d, want %0d", got.row, exp_r.row));
      if (got.last != exp_r.last)
        report($sformatf("last %0d, want %0d (col %0d row %0d)",
                         got.last, exp_r.last, exp_r.column, exp_r.row));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_pixel;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             out_median;
  logic [OUT_COL_W-1:0]   out_centre_column;
  logic [ROW_W-1:0]       out_centre_row;
  logic                   out_last;

  median_scoreboard sb;
  int burst_left;
  int pixel_total;
  int image_total;
  int stall_mode;
  int stall_cycle;

  window_median_filter_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_median        (out_median),
    .out_centre_column (out_centre_column),
    .out_centre_row    (out_centre_row),
    .out_last          (out_last)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver stall: switch between no stall, random stall and stall runs
  always @(negedge clk) begin
    if (stall_cycle == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_cycle <= $urandom_range(50, 300);
    end else begin
      stall_cycle <= stall_cycle - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((stall_cycle % 9) < 5);
    endcase
  end

  // Note accepted pixels and check accepted results
  always @(posedge clk) begin
    filt_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_pixel);
      if (out_valid && !out_stall) begin
        got.median = out_median;
        got.column = out_centre_column;
        got.row    = out_centre_row;
        got.last   = out_last;
        sb.check_result(got);
      end
    end
  end

  task write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold valid until the transaction is taken; open a gap between most bursts
  task send_pixel(logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
  endtask

  function logic [7:0] pick_pixel(int mode);
    case (mode)
      1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      2: return 8'hFF;
      3: return 8'h00;
      4: return 8'($urandom_range(118, 138));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Configure, stream one whole image, then drain before the next setting
  task run_image(int w, int h, int r, int mode);
    int count;
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_WINDOW_RADIUS, CFG_DATA_W'(r));
    count = sb.eff_width() * sb.eff_height();
    for (int i = 0; i < count; i++) send_pixel(pick_pixel(mode));
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    pixel_total += count;
    image_total++;
  endtask

  initial begin
    #50_000_000;
    $display("timeout at %0t", $realtime);
    $display("FAIL window_median_filter_unit");
    $finish;
  end

  initial begin
    int w, h, r;
    int rand_pixels;
    sb          = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_pixel    = '0;
    out_stall   = 1'b0;
    stall_mode  = 0;
    stall_cycle = 0;
    burst_left  = 0;
    pixel_total = 0;
    image_total = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed: extremes, zero and oversize settings, radii 0 to 3, narrow images
    run_image(5, 5, 1, 2);
    run_image(5, 5, 1, 3);
    run_image(3, 3, 1, 0);
    run_image(6, 5, 2, 1);
    run_image(5, 5, 2, 0);
    run_image(0, 3, 1, 0);
    run_image(4, 0, 0, 0);
    run_image(4, 4, 3, 0);
    run_image(7, 6, 3, 0);
    run_image(2047, 1, 0, 0);
    run_image(1, 40, 0, 1);

    // Random images, mostly small, with ties and clustered values
    rand_pixels = pixel_total;
    while (pixel_total - rand_pixels < 100) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      r = $urandom_range(0, 3);
      run_image(w, h, r, $urandom_range(0, 4));
    end

    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    $display("covered %0d images, %0d pixels, %0d medians checked",
             image_total, pixel_total, sb.results);
    if (sb.errors == 0)
      $display("PASS window_median_filter_unit");
    else
      $display("FAIL window_median_filter_unit");
    $finish;
  end

endmodule
